[hw/rtl/polar_to_cartesian_bins_defines.svh]
// Assertion macros shared by the polar to rectangular converter RTL.
`ifndef POLAR_TO_CARTESIAN_BINS_DEFINES_SVH
`define POLAR_TO_CARTESIAN_BINS_DEFINES_SVH

// Clocked check that is switched off while reset is high.
`define P2C_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds through reset.
`define P2C_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hw/rtl/p2c_pkg.sv]
// Types, constants and arithmetic helpers for the polar to rectangular converter.
package p2c_pkg;

  localparam int MAG_W  = 24;
  localparam int BIN_W  = 13;
  localparam int TRIG_W = 32;
  localparam int Z_W    = 28;
  localparam int PROD_W = 56;
  localparam int PAIRS  = 12;

  localparam logic [BIN_W-1:0] MAX_HALF_SIZE = 13'd4096;
  localparam logic [BIN_W-1:0] HFS_RESET     = 13'd256;
  localparam logic [BIN_W-1:0] HFS_MIN       = 13'd1;

  // Angles in Q24 radians.
  localparam logic signed [Z_W-1:0] TWO_PI_Q24  = 28'sd105414357;
  localparam logic signed [Z_W-1:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;

  // CORDIC gain compensation, Q30.
  localparam logic signed [TRIG_W-1:0] CORDIC_K_Q30 = 32'sd652032874;

  // Saturation bounds on the rounded product.
  localparam logic signed [26:0] SAT_HI = 27'sd8388607;
  localparam logic signed [26:0] SAT_LO = -27'sd8388608;
  localparam logic signed [MAG_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [MAG_W-1:0] OUT_MIN = 24'sh800000;
  localparam logic signed [56:0] ROUND_HALF = 57'sd536870912;

  typedef struct packed {
    logic signed [MAG_W-1:0] magnitude;
    logic signed [23:0]      phase;
    logic [BIN_W-1:0]        bin_index;
  } p2c_in_t;

  typedef struct packed {
    logic signed [MAG_W-1:0] real_part;
    logic signed [MAG_W-1:0] imag_part;
  } p2c_out_t;

  // Per-request data carried alongside the rotation.
  typedef struct packed {
    logic signed [MAG_W-1:0] mag;
    logic                    flip;
    logic                    nyq;
  } p2c_side_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [Z_W-1:0]    z;
  } p2c_rot_t;

  // Arctangent of 2^-i in Q24 radians.
  function automatic logic [23:0] atan_q24(input int unsigned i);
    logic [23:0] a;
    case (i)
      0:       a = 24'd13176795;
      1:       a = 24'd7778716;
      2:       a = 24'd4110060;
      3:       a = 24'd2086331;
      4:       a = 24'd1047214;
      5:       a = 24'd524117;
      6:       a = 24'd262123;
      7:       a = 24'd131069;
      8:       a = 24'd65536;
      9:       a = 24'd32768;
      10:      a = 24'd16384;
      11:      a = 24'd8192;
      12:      a = 24'd4096;
      13:      a = 24'd2048;
      14:      a = 24'd1024;
      15:      a = 24'd512;
      16:      a = 24'd256;
      17:      a = 24'd128;
      18:      a = 24'd64;
      19:      a = 24'd32;
      20:      a = 24'd16;
      21:      a = 24'd8;
      22:      a = 24'd4;
      23:      a = 24'd2;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

  // One rotation-mode CORDIC iteration; shifts floor toward minus infinity.
  function automatic p2c_rot_t cordic_iter(input p2c_rot_t v, input int unsigned i);
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [Z_W-1:0]    z;
    logic signed [Z_W-1:0]    a;
    p2c_rot_t                 r;
    x  = v.x;
    y  = v.y;
    z  = v.z;
    xs = x >>> i;
    ys = y >>> i;
    a  = Z_W'(atan_q24(i));
    if (!z[Z_W-1]) begin
      r.x = x - ys;
      r.y = y + xs;
      r.z = z - a;
    end else begin
      r.x = x + ys;
      r.y = y - xs;
      r.z = z + a;
    end
    return r;
  endfunction

  // Two consecutive iterations, the work of one pipeline stage.
  function automatic p2c_rot_t cordic_pair(input p2c_rot_t v, input int unsigned p);
    return cordic_iter(cordic_iter(v, 2 * p), 2 * p + 1);
  endfunction

  // Round a Q46 product to Q8.16 (half up, floor shift) and saturate.
  function automatic logic signed [MAG_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [56:0] t;
    logic signed [26:0] r;
    logic signed [MAG_W-1:0] o;
    t = 57'(p) + ROUND_HALF;
    r = t[56:30];
    if (r > SAT_HI) begin
      o = OUT_MAX;
    end else if (r < SAT_LO) begin
      o = OUT_MIN;
    end else begin
      o = r[MAG_W-1:0];
    end
    return o;
  endfunction

endpackage

[hw/rtl/p2c_cordic.sv]
// Pipelined rotation-mode CORDIC, two iterations per register stage.
module p2c_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic signed [27:0] in_z,
  input  p2c_pkg::p2c_side_t in_side,
  output logic              out_valid,
  output p2c_pkg::p2c_rot_t out_rot,
  output p2c_pkg::p2c_side_t out_side
);
  import p2c_pkg::*;

  logic [PAIRS-1:0] valid;
  p2c_rot_t         rot [PAIRS];
  p2c_side_t        side [PAIRS];
  p2c_rot_t         rot_next [PAIRS];
  p2c_rot_t         rot_init;

  // Every request starts on the x axis with the gain already removed.
  always_comb begin
    rot_init.x = CORDIC_K_Q30;
    rot_init.y = '0;
    rot_init.z = in_z;
  end

  // Next value of every stage from the one before it.
  always_comb begin
    rot_next[0] = cordic_pair(rot_init, 0);
    for (int p = 1; p < PAIRS; p++) begin
      rot_next[p] = cordic_pair(rot[p-1], p);
    end
  end

  // Valid bits advance with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[PAIRS-2:0], in_valid};
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int p = 0; p < PAIRS; p++) begin
        rot[p] <= rot_next[p];
      end
      for (int p = 1; p < PAIRS; p++) begin
        side[p] <= side[p-1];
      end
    end
  end

  assign out_valid = valid[PAIRS-1];
  assign out_rot   = rot[PAIRS-1];
  assign out_side  = side[PAIRS-1];

endmodule

[hw/rtl/polar_to_cartesian_bins.sv]
// Polar to rectangular conversion of spectral bins, top level.
// Throughput: one request per cycle while the skid entry is empty, through the 12-stage CORDIC and one multiply stage.
// A two-entry output (register plus skid) lets input continue while a result waits.
// Synchronous reset empties the pipeline and sets half_frame_size to 256.
module polar_to_cartesian_bins (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [12:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  p2c_pkg::p2c_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output p2c_pkg::p2c_out_t out_data
);
  import p2c_pkg::*;
  `include "polar_to_cartesian_bins_defines.svh"

  logic [BIN_W-1:0] half_frame_size;
  logic [BIN_W-1:0] nyq_bin;
  logic             pipe_en;

  logic                  red_valid;
  logic signed [Z_W-1:0] red_z;
  logic signed [Z_W-1:0] red_z_next;
  logic signed [Z_W-1:0] phase_q24;
  p2c_side_t             red_side;

  logic                  fold_valid;
  logic signed [Z_W-1:0] fold_z;
  logic signed [Z_W-1:0] fold_z_next;
  logic                  fold_flip_next;
  p2c_side_t             fold_side;

  logic      cor_valid;
  p2c_rot_t  cor_rot;
  p2c_side_t cor_side;

  logic                     sgn_valid;
  logic signed [TRIG_W-1:0] sgn_cos;
  logic signed [TRIG_W-1:0] sgn_sin;
  logic signed [MAG_W-1:0]  sgn_mag;
  logic                     sgn_nyq;

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic                     prod_nyq;
  p2c_out_t                 result;

  logic     skid_valid;
  p2c_out_t skid_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_frame_size <= HFS_RESET;
    end else if (cfg_we) begin
      half_frame_size <= cfg_data;
    end
  end

  // Clamp the Nyquist index into its legal range.
  always_comb begin
    if (half_frame_size < HFS_MIN) begin
      nyq_bin = HFS_MIN;
    end else if (half_frame_size > MAX_HALF_SIZE) begin
      nyq_bin = MAX_HALF_SIZE;
    end else begin
      nyq_bin = half_frame_size;
    end
  end

  // The whole pipeline moves unless the skid entry is occupied.
  assign pipe_en  = !skid_valid;
  assign in_ready = pipe_en;

  // Stage 1: widen the phase to Q24 and reduce it into [-pi, pi].
  always_comb begin
    phase_q24 = {in_data.phase, 4'b0000};
    if (phase_q24 > PI_Q24) begin
      red_z_next = phase_q24 - TWO_PI_Q24;
    end else if (phase_q24 < -PI_Q24) begin
      red_z_next = phase_q24 + TWO_PI_Q24;
    end else begin
      red_z_next = phase_q24;
    end
  end

  // Stage 2: fold into [-pi/2, pi/2] and note the sign flip.
  always_comb begin
    if (red_z > HALF_PI_Q24) begin
      fold_z_next    = red_z - PI_Q24;
      fold_flip_next = 1'b1;
    end else if (red_z < -HALF_PI_Q24) begin
      fold_z_next    = red_z + PI_Q24;
      fold_flip_next = 1'b1;
    end else begin
      fold_z_next    = red_z;
      fold_flip_next = 1'b0;
    end
  end

  // Valid bits of the front and back stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_valid  <= 1'b0;
      fold_valid <= 1'b0;
      sgn_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else if (pipe_en) begin
      red_valid  <= in_valid;
      fold_valid <= red_valid;
      sgn_valid  <= cor_valid;
      prod_valid <= sgn_valid;
    end
  end

  // Payload registers of the front and back stages.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      red_z         <= red_z_next;
      red_side.mag  <= in_data.magnitude;
      red_side.flip <= 1'b0;
      red_side.nyq  <= (in_data.bin_index == nyq_bin);

      fold_z         <= fold_z_next;
      fold_side.mag  <= red_side.mag;
      fold_side.flip <= fold_flip_next;
      fold_side.nyq  <= red_side.nyq;

      // Apply the quadrant flip and the negation of the sine.
      sgn_cos <= cor_side.flip ? -cor_rot.x : cor_rot.x;
      sgn_sin <= cor_side.flip ? cor_rot.y : -cor_rot.y;
      sgn_mag <= cor_side.mag;
      sgn_nyq <= cor_side.nyq;

      prod_re  <= sgn_mag * sgn_cos;
      prod_im  <= sgn_mag * sgn_sin;
      prod_nyq <= sgn_nyq;
    end
  end

  p2c_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (fold_valid),
    .in_z      (fold_z),
    .in_side   (fold_side),
    .out_valid (cor_valid),
    .out_rot   (cor_rot),
    .out_side  (cor_side)
  );

  // Round and saturate; the imaginary part is zero at the Nyquist bin.
  always_comb begin
    result.real_part = round_sat(prod_re);
    result.imag_part = prod_nyq ? '0 : round_sat(prod_im);
  end

  // Output register and skid entry control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= prod_valid;
      end
    end else if (prod_valid && pipe_en) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid entry data.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (prod_valid && pipe_en) begin
      skid_data <= result;
    end
  end

  `P2C_ASSERT(a_skid_needs_out, skid_valid |-> out_valid, "skid entry full with output empty")
  `P2C_ASSERT(a_stall_fills_skid, (out_valid && !out_ready && prod_valid && !skid_valid) |=> skid_valid, "stalled result was not parked")
  `P2C_ASSERT(a_skid_drains, (skid_valid && out_ready) |=> (out_valid && !skid_valid), "skid entry did not move to output")
  `P2C_ASSERT(a_hold_when_full, skid_valid |=> (prod_valid == $past(prod_valid)), "pipeline moved while skid was full")
  `P2C_ASSERT_RST(a_reset_empty, rst |=> (!out_valid && !skid_valid && !prod_valid), "reset left a request in flight")

endmodule

[sim/bin_scoreboard_pkg.sv]
// Scoreboard class that predicts and checks converted spectral bins.
package bin_scoreboard_pkg;
  import p2c_pkg::*;

  localparam int CORDIC_STEPS = 24;

  // Angles in Q24 radians and the CORDIC gain correction in Q30.
  localparam longint FULL_TURN_Z = 64'sd105414357;
  localparam longint HALF_TURN_Z = 64'sd52707179;
  localparam longint QUARTER_TURN_Z = 64'sd26353589;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint Q16_TOP = 64'sd8388607;
  localparam longint Q16_BOTTOM = -64'sd8388608;
  localparam int NYQUIST_CEILING = 4096;

  // Arctangent of 2^-i, Q24 radians.
  localparam longint ATAN_STEP_Z [CORDIC_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  class bin_scoreboard;
    p2c_out_t expected_bins[$];
    logic [BIN_W-1:0] half_size;
    int unsigned errors;
    int unsigned converted;
    int unsigned nyquist_hits;

    function new();
      half_size = 13'd256;
      errors = 0;
      converted = 0;
      nyquist_hits = 0;
    endfunction

    function void set_half_size(input logic [BIN_W-1:0] value);
      half_size = value;
    endfunction

    function int unsigned pending();
      return expected_bins.size();
    endfunction

    // Zero acts as one and anything past the ceiling acts as the ceiling.
    function logic [BIN_W-1:0] nyquist_bin();
      if (half_size == 0) begin
        return 13'd1;
      end
      if (half_size > NYQUIST_CEILING) begin
        return 13'(NYQUIST_CEILING);
      end
      return half_size;
    endfunction

    // Reduce the phase into the right half plane, then rotate the gain-corrected
    // unit vector; a reduction by half a turn flips both results.
    function void rotate_phase(input logic signed [23:0] phase,
                               output longint cos_q30, output longint sin_q30);
      longint ang;
      longint x;
      longint y;
      longint x_next;
      bit mirrored;
      ang = longint'(phase) * 16;
      x = GAIN_Q30;
      y = 0;
      mirrored = 1'b0;
      while (ang > HALF_TURN_Z) ang -= FULL_TURN_Z;
      while (ang < -HALF_TURN_Z) ang += FULL_TURN_Z;
      if (ang > QUARTER_TURN_Z) begin
        ang -= HALF_TURN_Z;
        mirrored = 1'b1;
      end else if (ang < -QUARTER_TURN_Z) begin
        ang += HALF_TURN_Z;
        mirrored = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (ang >= 0) begin
          x_next = x - (y >>> i);
          y = y + (x >>> i);
          ang -= ATAN_STEP_Z[i];
        end else begin
          x_next = x + (y >>> i);
          y = y - (x >>> i);
          ang += ATAN_STEP_Z[i];
        end
        x = x_next;
      end
      cos_q30 = mirrored ? -x : x;
      sin_q30 = mirrored ? -y : y;
    endfunction

    // Round a Q46 product half up to Q8.16 and clamp it to the output range.
    function logic signed [23:0] scale_to_q16(input longint prod);
      longint r;
      r = (prod + (64'sd1 <<< 29)) >>> 30;
      if (r > Q16_TOP) r = Q16_TOP;
      if (r < Q16_BOTTOM) r = Q16_BOTTOM;
      return r[23:0];
    endfunction

    function p2c_out_t to_rectangular(input p2c_in_t req);
      p2c_out_t res;
      longint mag;
      longint c;
      longint s;
      mag = longint'(req.magnitude);
      rotate_phase(req.phase, c, s);
      res.real_part = scale_to_q16(mag * c);
      if (req.bin_index == nyquist_bin()) begin
        res.imag_part = '0;
      end else begin
        res.imag_part = scale_to_q16(-(mag * s));
      end
      return res;
    endfunction

    function void note_request(input p2c_in_t req);
      if (req.bin_index == nyquist_bin()) nyquist_hits++;
      expected_bins.push_back(to_rectangular(req));
    endfunction

    // Compare a result with the oldest outstanding prediction.
    function void check_result(input p2c_out_t got);
      p2c_out_t want;
      if (expected_bins.size() == 0) begin
        errors++;
        $error("Result with no request outstanding: real_part %0d, imag_part %0d",
               got.real_part, got.imag_part);
        return;
      end
      want = expected_bins.pop_front();
      converted++;
      if (got.real_part !== want.real_part) begin
        errors++;
        $error("real_part: expected %0d, got %0d", want.real_part, got.real_part);
      end
      if (got.imag_part !== want.imag_part) begin
        errors++;
        $error("imag_part: expected %0d, got %0d", want.imag_part, got.imag_part);
      end
    endfunction
  endclass

endpackage

[sim/tb_top.sv]
// Top-level testbench for the polar to rectangular bin converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import p2c_pkg::*;
  import bin_scoreboard_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_PAUSE = 4;
  localparam int SETTING_COUNT = 9;
  localparam int BINS_PER_SETTING = 72;

  // Field extremes and phases on either side of the reduction boundaries (Q4.20).
  localparam int MAG_TOP = 8388607;
  localparam int MAG_BOTTOM = -8388608;
  localparam int PH_TOP = 8388607;
  localparam int PH_BOTTOM = -8388608;
  localparam int PH_PAST_PI = 3294199;
  localparam int PH_PAST_HALF_PI = 1647100;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [12:0] cfg_data;
  logic in_valid;
  logic in_ready;
  p2c_in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  p2c_out_t out_data;

  bin_scoreboard board;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_left = 0;

  always #10 clk = ~clk;

  polar_to_cartesian_bins i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Result side: random stalls.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(1, 100) <= recv_stall_pct) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Handshakes are sampled mid-cycle, when every signal has settled for the next edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_request(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  // End the run if neither side moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("Nothing moved for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic p2c_in_t make_bin(input int mag, input int ph, input int bin);
    p2c_in_t req;
    req.magnitude = 24'(mag);
    req.phase = 24'(ph);
    req.bin_index = 13'(bin);
    return req;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 25;
      default: return 45;
    endcase
  endfunction

  // Random bin, weighted toward the Nyquist index, saturating magnitudes and
  // phases next to the quarter and half turn boundaries.
  function automatic p2c_in_t random_bin();
    p2c_in_t req;
    int ph;
    logic [12:0] nyq;
    nyq = board.nyquist_bin();
    req.magnitude = 24'($urandom);
    req.phase = 24'($urandom);
    req.bin_index = 13'($urandom);
    case ($urandom_range(0, 7))
      0: req.magnitude = 24'(MAG_BOTTOM);
      1: req.magnitude = 24'(MAG_TOP);
      2: req.magnitude = 24'($signed($urandom_range(0, 511)) - 256);
      default: ;
    endcase
    ph = 0;
    case ($urandom_range(0, 7))
      0: ph = PH_PAST_PI - int'($urandom_range(0, 1));
      1: ph = PH_PAST_HALF_PI - int'($urandom_range(0, 1));
      2: ph = $urandom_range(0, 1) ? PH_TOP : PH_BOTTOM;
      default: ph = int'(req.phase);
    endcase
    if ($urandom_range(0, 1) && ph != PH_BOTTOM && ph != PH_TOP) ph = -ph;
    req.phase = 24'(ph);
    case ($urandom_range(0, 9))
      0, 1, 2: req.bin_index = nyq;
      3: req.bin_index = board.half_size;
      4: req.bin_index = nyq + 13'd1;
      5: req.bin_index = nyq - 13'd1;
      6: req.bin_index = '0;
      7: ;
      default: req.bin_index = 13'($urandom_range(0, nyq));
    endcase
    return req;
  endfunction

  // Present one request, with an optional gap first, and return at the edge
  // that takes it.
  task automatic send_bin(input p2c_in_t req);
    if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_half_size(input logic [12:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_half_size(value);
  endtask

  initial begin : stimulus
    logic [12:0] settings [SETTING_COUNT];
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;

    settings[0] = 13'd0;
    settings[1] = 13'd1;
    settings[2] = 13'd4096;
    settings[3] = 13'd8191;
    settings[4] = 13'($urandom_range(2, 4095));
    settings[5] = 13'($urandom_range(4097, 8190));
    settings[6] = 13'd4095;
    settings[7] = 13'd2;
    settings[8] = 13'd256;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed bins at the reset half size, where bin 256 is Nyquist.
    send_gap_pct = 20;
    recv_stall_pct = 20;
    send_bin(make_bin(MAG_TOP, 0, 0));
    send_bin(make_bin(MAG_BOTTOM, 0, 1));
    send_bin(make_bin(MAG_BOTTOM, PH_PAST_PI, 2));
    send_bin(make_bin(MAG_TOP, PH_PAST_PI - 1, 3));
    send_bin(make_bin(MAG_TOP, -PH_PAST_PI, 4));
    send_bin(make_bin(MAG_BOTTOM, -(PH_PAST_PI - 1), 5));
    send_bin(make_bin(MAG_TOP, PH_PAST_HALF_PI - 1, 6));
    send_bin(make_bin(MAG_TOP, PH_PAST_HALF_PI, 7));
    send_bin(make_bin(MAG_BOTTOM, -(PH_PAST_HALF_PI - 1), 8));
    send_bin(make_bin(MAG_TOP, -PH_PAST_HALF_PI, 9));
    send_bin(make_bin(MAG_TOP, PH_TOP, 10));
    send_bin(make_bin(MAG_BOTTOM, PH_BOTTOM, 11));
    send_bin(make_bin(0, 1234567, 256));
    send_bin(make_bin(MAG_TOP, 1000000, 256));
    send_bin(make_bin(MAG_BOTTOM, -5000000, 256));
    send_bin(make_bin(MAG_TOP, 1000000, 257));
    send_bin(make_bin(MAG_TOP, 1000000, 8191));
    send_bin(make_bin(1, 0, 255));
    send_bin(make_bin(-1, PH_PAST_PI, 4096));
    send_bin(make_bin(65536, 823550, 100));
    send_bin(make_bin(5592405, 2796202, 2730));
    send_bin(make_bin(-5592406, -2796203, 5461));

    // Random bins under each half size; the last setting runs without idling.
    // The idle rates change before the drain so no stall spills into the next setting.
    for (int s = 0; s < SETTING_COUNT; s++) begin
      if (s == SETTING_COUNT - 1) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_gap_pct = pick_idle_pct();
        recv_stall_pct = pick_idle_pct();
      end
      write_half_size(settings[s]);
      repeat (BINS_PER_SETTING) send_bin(random_bin());
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d bins under %0d half-size settings plus reset, %0d at Nyquist.",
             board.converted, SETTING_COUNT, board.nyquist_hits);
    $display("Field mismatches and unmatched results: %0d.", board.errors);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
